@@ rtl/core/mscp_pkg.sv @@
// Shared types, code constants and the start code classifier
// for the MPEG-1 start code parser. No dependencies.
`timescale 1ns / 1ps

package mscp_pkg;

   localparam logic [1:0] PHASE_SCAN   = 2'd0;
   localparam logic [1:0] PHASE_CODE   = 2'd1;
   localparam logic [1:0] PHASE_HEAD   = 2'd2;
   localparam logic [1:0] PHASE_UNUSED = 2'd3;

   localparam logic [3:0] KIND_PACK     = 4'd0;
   localparam logic [3:0] KIND_SYSTEM   = 4'd1;
   localparam logic [3:0] KIND_SEQUENCE = 4'd2;
   localparam logic [3:0] KIND_GOP      = 4'd3;
   localparam logic [3:0] KIND_PICTURE  = 4'd4;
   localparam logic [3:0] KIND_SLICE    = 4'd5;
   localparam logic [3:0] KIND_VIDEO    = 4'd6;
   localparam logic [3:0] KIND_AUDIO    = 4'd7;
   localparam logic [3:0] KIND_UNKNOWN  = 4'd8;

   localparam logic [7:0] CODE_PICTURE   = 8'h00;
   localparam logic [7:0] CODE_SLICE_LO  = 8'h01;
   localparam logic [7:0] CODE_SLICE_HI  = 8'hAF;
   localparam logic [7:0] CODE_SEQUENCE  = 8'hB3;
   localparam logic [7:0] CODE_GOP       = 8'hB8;
   localparam logic [7:0] CODE_PACK      = 8'hBA;
   localparam logic [7:0] CODE_SYSTEM    = 8'hBB;
   localparam logic [7:0] CODE_AUDIO_LO  = 8'hC0;
   localparam logic [7:0] CODE_AUDIO_HI  = 8'hDF;
   localparam logic [7:0] CODE_VIDEO_LO  = 8'hE0;
   localparam logic [7:0] CODE_VIDEO_HI  = 8'hEF;
   localparam logic [7:0] PREFIX_END     = 8'h01;

   // Packed MSB first, so start_code lands in the lowest bits.
   typedef struct packed {
      logic [2:0]  coding_type;
      logic [3:0]  rate_code;
      logic [11:0] frame_height;
      logic [11:0] frame_width;
      logic [3:0]  code_kind;
      logic [7:0]  start_code;
   } mscp_result_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [1:0] zero_run;
      logic [1:0] payload_index;
   } mscp_status_type;

   function automatic logic [3:0] classify(input logic [7:0] code);
      logic [3:0] kind;
      priority if (code == CODE_PACK)      kind = KIND_PACK;
      else if (code == CODE_SYSTEM)        kind = KIND_SYSTEM;
      else if (code == CODE_SEQUENCE)      kind = KIND_SEQUENCE;
      else if (code == CODE_GOP)           kind = KIND_GOP;
      else if (code == CODE_PICTURE)       kind = KIND_PICTURE;
      else if (code >= CODE_SLICE_LO && code <= CODE_SLICE_HI) kind = KIND_SLICE;
      else if (code >= CODE_AUDIO_LO && code <= CODE_AUDIO_HI) kind = KIND_AUDIO;
      else if (code >= CODE_VIDEO_LO && code <= CODE_VIDEO_HI) kind = KIND_VIDEO;
      else                                 kind = KIND_UNKNOWN;
      return kind;
   endfunction

endpackage

@@ rtl/core/mscp_parser.sv @@
// Byte-wise prefix scanner and header field extractor.
// Depends on mscp_pkg; result is combinational from the current beat.
`timescale 1ns / 1ps

module mscp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_take,
   input  logic [7:0]               data_byte,
   output logic                     result_valid,
   output mscp_pkg::mscp_result_type result,
   output mscp_pkg::mscp_status_type status
);
   import mscp_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [1:0] zero_run_ff, zero_run_in;
   logic [1:0] payload_index_ff, payload_index_in;
   logic [7:0] held_code_ff, held_code_in;
   logic [7:0] held_bytes_ff [3];
   logic       held_we;

   always_comb begin
      phase_in         = phase_ff;
      zero_run_in      = zero_run_ff;
      payload_index_in = payload_index_ff;
      held_code_in     = held_code_ff;
      held_we          = 1'b0;
      result_valid     = 1'b0;
      result           = '0;
      result.start_code = data_byte;
      unique case (phase_ff)
         PHASE_CODE: begin
            if (data_byte == CODE_SEQUENCE || data_byte == CODE_PICTURE) begin
               held_code_in     = data_byte;
               payload_index_in = 2'd0;
               phase_in         = PHASE_HEAD;
            end else begin
               result_valid     = 1'b1;
               phase_in         = PHASE_SCAN;
               zero_run_in      = 2'd0;
               payload_index_in = 2'd0;
            end
         end
         PHASE_HEAD: begin
            if (held_code_ff == CODE_SEQUENCE) begin
               if (payload_index_ff < 2'd3) begin
                  held_we          = 1'b1;
                  payload_index_in = payload_index_ff + 2'd1;
               end else begin
                  result_valid        = 1'b1;
                  result.start_code   = CODE_SEQUENCE;
                  result.frame_width  = {held_bytes_ff[0], held_bytes_ff[1][7:4]};
                  result.frame_height = {held_bytes_ff[1][3:0], held_bytes_ff[2]};
                  result.rate_code    = data_byte[3:0];
               end
            end else begin
               if (payload_index_ff < 2'd1) begin
                  held_we          = 1'b1;
                  payload_index_in = 2'd1;
               end else begin
                  result_valid       = 1'b1;
                  result.start_code  = CODE_PICTURE;
                  result.coding_type = data_byte[5:3];
               end
            end
            if (result_valid) begin
               phase_in         = PHASE_SCAN;
               zero_run_in      = 2'd0;
               payload_index_in = 2'd0;
            end
         end
         default: begin
            // scanning; the unused phase code behaves the same
            if (data_byte == 8'h00) begin
               if (zero_run_ff < 2'd2) zero_run_in = zero_run_ff + 2'd1;
               phase_in = PHASE_SCAN;
            end else if (data_byte == PREFIX_END && zero_run_ff == 2'd2) begin
               zero_run_in = 2'd0;
               phase_in    = PHASE_CODE;
            end else begin
               zero_run_in = 2'd0;
               phase_in    = PHASE_SCAN;
            end
         end
      endcase
      result.code_kind = classify(result.start_code);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_SCAN;
         zero_run_ff      <= 2'd0;
         payload_index_ff <= 2'd0;
      end else if (byte_take) begin
         phase_ff         <= phase_in;
         zero_run_ff      <= zero_run_in;
         payload_index_ff <= payload_index_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (byte_take) begin
         held_code_ff <= held_code_in;
         if (held_we) held_bytes_ff[payload_index_ff] <= data_byte;
      end
   end

   assign status = '{phase: phase_ff, zero_run: zero_run_ff,
                     payload_index: payload_index_ff};

endmodule

@@ rtl/core/mpeg_start_code_parser_top.sv @@
// MPEG-1 start code parser top: stream ports and the result register.
// Depends on mscp_pkg and mscp_parser.
// A result appears on rsp_tvalid in the cycle after the beat that completes it.
// Throughput: one byte per clock; set by the single parse step feeding the result register.
// A full result register stalls input only while rsp_tready is low.
// Reset (synchronous, active high) returns to prefix scan and drops any held result.
`timescale 1ns / 1ps

module mpeg_start_code_parser_top (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [7:0] start_code, [11:8] code_kind,
                                    // [23:12] frame_width, [35:24] frame_height,
                                    // [39:36] rate_code, [42:40] coding_type,
                                    // [47:43] zero
);
   import mscp_pkg::*;

   logic            req_take;
   logic            parse_valid;
   mscp_result_type parse_result;
   mscp_status_type parse_status;

   logic            rsp_valid_ff, rsp_valid_in;
   mscp_result_type rsp_data_ff;

   // Take a byte whenever the result register is free or drains this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   mscp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_take    (req_take),
      .data_byte    (req_tdata),
      .result_valid (parse_valid),
      .result       (parse_result),
      .status       (parse_status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_take && parse_valid) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && parse_valid) rsp_data_ff <= parse_result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

   // parser never enters the unused phase
   a_phase_used: assert property (@(posedge clock) disable iff (reset)
      parse_status.phase != PHASE_UNUSED)
      else $error("parser in unused phase");

   // size and rate fields only carry data for a sequence header
   a_seq_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.code_kind != KIND_SEQUENCE) |->
      (rsp_data_ff.frame_width == 12'd0 && rsp_data_ff.frame_height == 12'd0 &&
       rsp_data_ff.rate_code == 4'd0))
      else $error("sequence fields set on other code");

   // every produced result restarts the prefix scan
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_take && parse_valid) |=>
      (parse_status.phase == PHASE_SCAN && parse_status.zero_run == 2'd0 &&
       parse_status.payload_index == 2'd0 && rsp_tvalid))
      else $error("scan not restarted after result");

endmodule

@@ dv/mpeg_start_code_parser_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for mpeg_start_code_parser_top: byte beats in, decoded start codes out.
// Depends on mscp_pkg and the parser RTL; carries its own byte-level predictor.

module mpeg_start_code_parser_top_tb;
   import mscp_pkg::*;

   // idle cycles with no beat on either side before the run is abandoned
   localparam int STALL_LIMIT = 5000;
   // settle time after the drain, covering the result register
   localparam int TAIL_CYCLES = 10;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_LENGTH = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [7:0] start_code, [11:8] code_kind,
                                      // [23:12] frame_width, [35:24] frame_height,
                                      // [39:36] rate_code, [42:40] coding_type

   // parser state as the predictor sees it
   logic [1:0]  parse_state = PHASE_SCAN;
   logic [1:0]  scan_zeros  = 2'd0;
   logic [1:0]  hdr_count   = 2'd0;
   logic [7:0]  hdr_bytes [3];
   logic [7:0]  hdr_code;

   mscp_result_type pending_codes [$];   // decoded codes not yet seen on rsp

   int error_count = 0;
   int beats_sent  = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_cycles = 0;                  // receiver hold-off, counted down by the receiver

   mpeg_start_code_parser_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [3:0] kind_of_code(input logic [7:0] c);
      if (c == CODE_PACK)                                return KIND_PACK;
      if (c == CODE_SYSTEM)                              return KIND_SYSTEM;
      if (c == CODE_SEQUENCE)                            return KIND_SEQUENCE;
      if (c == CODE_GOP)                                 return KIND_GOP;
      if (c == CODE_PICTURE)                             return KIND_PICTURE;
      if (c >= CODE_SLICE_LO && c <= CODE_SLICE_HI)      return KIND_SLICE;
      if (c >= CODE_AUDIO_LO && c <= CODE_AUDIO_HI)      return KIND_AUDIO;
      if (c >= CODE_VIDEO_LO && c <= CODE_VIDEO_HI)      return KIND_VIDEO;
      return KIND_UNKNOWN;
   endfunction

   // Advance the predicted parser by one byte; returns 1 when the byte completes a code.
   function automatic bit parse_byte(input logic [7:0] b, output mscp_result_type res);
      bit done;
      done = 1'b0;
      res  = '0;
      case (parse_state)
         PHASE_CODE: begin
            if (b == CODE_SEQUENCE || b == CODE_PICTURE) begin
               // code with header bytes: hold it until the header is in
               hdr_code    = b;
               hdr_count   = 2'd0;
               parse_state = PHASE_HEAD;
            end else begin
               res.start_code = b;
               res.code_kind  = kind_of_code(b);
               done = 1'b1;
            end
         end
         PHASE_HEAD: begin
            if (hdr_code == CODE_SEQUENCE) begin
               if (hdr_count < 2'd3) begin
                  hdr_bytes[hdr_count] = b;
                  hdr_count = hdr_count + 2'd1;
               end else begin
                  res.start_code   = CODE_SEQUENCE;
                  res.code_kind    = kind_of_code(CODE_SEQUENCE);
                  res.frame_width  = {hdr_bytes[0], hdr_bytes[1][7:4]};
                  res.frame_height = {hdr_bytes[1][3:0], hdr_bytes[2]};
                  res.rate_code    = b[3:0];
                  done = 1'b1;
               end
            end else begin
               if (hdr_count == 2'd0) begin
                  hdr_bytes[0] = b;
                  hdr_count = 2'd1;
               end else begin
                  res.start_code  = CODE_PICTURE;
                  res.code_kind   = kind_of_code(CODE_PICTURE);
                  res.coding_type = b[5:3];
                  done = 1'b1;
               end
            end
         end
         default: begin
            // prefix scan; two or more zeros then 01 is a prefix
            if (b == 8'h00) begin
               if (scan_zeros < 2'd2) scan_zeros = scan_zeros + 2'd1;
               parse_state = PHASE_SCAN;
            end else if (b == PREFIX_END && scan_zeros >= 2'd2) begin
               scan_zeros  = 2'd0;
               parse_state = PHASE_CODE;
            end else begin
               scan_zeros  = 2'd0;
               parse_state = PHASE_SCAN;
            end
         end
      endcase
      if (done) begin
         // scan restarts clean after code and header
         parse_state = PHASE_SCAN;
         scan_zeros  = 2'd0;
         hdr_count   = 2'd0;
      end
      return done;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one byte beat. Called and returns at a falling edge; valid stays high on return.
   task automatic send_byte(input logic [7:0] value);
      mscp_result_type res;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (parse_byte(value, res)) pending_codes.push_back(res);
      beats_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted code has come out.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_codes.size() != 0);
   endtask

   // Receiver: long hold-off when asked, else random stalls at the current rate.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin : check_result
      mscp_result_type got;
      mscp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mscp_result_type'(rsp_tdata[42:0]);
         if (pending_codes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result beat: code %02h kind %0d", got.start_code,
                        got.code_kind);
         end else begin
            want = pending_codes.pop_front();
            if (got !== want || rsp_tdata[47:43] !== 5'b0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"mismatch (exp/got): code %02h/%02h kind %0d/%0d ",
                            "width %0d/%0d height %0d/%0d rate %0d/%0d type %0d/%0d pad %0h"},
                           want.start_code, got.start_code, want.code_kind, got.code_kind,
                           want.frame_width, got.frame_width,
                           want.frame_height, got.frame_height,
                           want.rate_code, got.rate_code,
                           want.coding_type, got.coding_type, rsp_tdata[47:43]);
            end
         end
      end
   end

   // Watchdog: ends the run after a long stretch with no beat on either side.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   // header byte: often 00/01 so prefixes show up inside headers
   function automatic logic [7:0] header_byte();
      if ($urandom_range(99) < 25) return $urandom_range(1) ? PREFIX_END : 8'h00;
      return 8'($urandom());
   endfunction

   // One piece of stream: mostly a full start code with random content,
   // else noise or a prefix that breaks off.
   task automatic send_random_unit();
      logic [7:0] code;
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) begin
         repeat ($urandom_range(2)) send_byte(8'h00);   // longer zero runs
         send_byte(8'h00);
         send_byte(8'h00);
         send_byte(PREFIX_END);
         case ($urandom_range(9))
            0: code = CODE_SEQUENCE;
            1: code = CODE_PICTURE;
            2: code = CODE_PACK;
            3: code = CODE_SYSTEM;
            4: code = CODE_GOP;
            5: code = 8'($urandom_range(CODE_SLICE_HI, CODE_SLICE_LO));
            6: code = 8'($urandom_range(CODE_AUDIO_HI, CODE_AUDIO_LO));
            7: code = 8'($urandom_range(CODE_VIDEO_HI, CODE_VIDEO_LO));
            8: code = $urandom_range(1) ? 8'($urandom_range(8'hFF, 8'hF0))
                                        : 8'($urandom_range(8'hBF, 8'hB0));
            default: code = 8'($urandom());
         endcase
         send_byte(code);
         if (code == CODE_SEQUENCE) repeat (4) send_byte(header_byte());
         else if (code == CODE_PICTURE) repeat (2) send_byte(header_byte());
      end else if (pick < 85) begin
         repeat ($urandom_range(6, 1)) send_byte(header_byte());
      end else begin
         // broken prefix: 00 01, or 00 00 followed by something other than 01
         send_byte(8'h00);
         if ($urandom_range(1)) begin
            send_byte(PREFIX_END);
         end else begin
            send_byte(8'h00);
            send_byte(8'($urandom_range(255, 2)));
         end
      end
   endtask

   // Extremes of the header fields, long zero run, prefix bytes inside a header.
   task automatic test_directed_codes();
      logic [7:0] stream [$];
      stream = '{8'h00, 8'h00, 8'h00, PREFIX_END, CODE_SEQUENCE,    // 00 00 00 01 found
                 8'hFF, 8'hFF, 8'hFF, 8'hFF,                       // all-ones sizes, rate 15
                 8'h00, 8'h00, PREFIX_END, CODE_SEQUENCE,
                 8'h00, 8'h00, PREFIX_END, 8'h00,                  // prefix inside header
                 8'h00, 8'h00, PREFIX_END, CODE_PICTURE,
                 8'h5A, 8'hF8,                                     // coding type 7
                 8'h00, 8'h00, PREFIX_END, CODE_PACK};
      foreach (stream[i]) send_byte(stream[i]);
   endtask

   task automatic test_random_stream(input int count);
      int target;
      target = beats_sent + count;
      while (beats_sent < target) send_random_unit();
   endtask

   // Receiver holds off while result-making beats keep coming: input must stall.
   task automatic test_full_stall();
      hold_cycles = HOLD_LENGTH;
      repeat (12) begin
         send_byte(8'h00);
         send_byte(8'h00);
         send_byte(PREFIX_END);
         send_byte($urandom_range(1) ? CODE_PACK : CODE_GOP);
      end
   endtask

   // Sender stops mid-stream until all results are out, then resumes.
   task automatic test_drain_pause();
      repeat (8) send_random_unit();
      wait_drained();
      repeat (8) send_random_unit();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 16;
      rx_idle_pct = 77;
      test_directed_codes();
      test_random_stream(520);
      test_drain_pause();

      tx_idle_pct = 77;
      rx_idle_pct = 16;
      test_random_stream(520);
      test_full_stall();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_stream(520);

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_codes.size() != 0) begin
         $display("results never seen: %0d", pending_codes.size());
         error_count += pending_codes.size();
      end
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
